>>> src/rfg_pkg.sv
// ----------------------------------------------------------------------------
// rfg_pkg: shared types for the fraction reduction block
// Command and status groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package rfg_pkg;

	// Controller to datapath commands, at most one active per cycle
	typedef struct packed {
		logic load;      // capture a new fraction
		logic gcd_step;  // one binary gcd step
		logic scale;     // restore common factors of two, clear remainders
		logic div_step;  // one restoring division step on both quotients
		logic out_load;  // move the finished result into the output register
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic denom_zero; // denominator held is zero
		logic a_zero;     // gcd search operand has reached zero
	} status_t;

endpackage

>>> src/rfg_in_if.sv
// ----------------------------------------------------------------------------
// rfg_in_if: input channel of the fraction reduction block
// Valid/ready channel carrying one fraction per item.
// ----------------------------------------------------------------------------
interface rfg_in_if #(
	parameter int WIDTH = 32
) ();
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] numer_in;
	logic [WIDTH-1:0] denom_in;

	modport source (output valid, output numer_in, output denom_in, input ready);
	modport sink   (input valid, input numer_in, input denom_in, output ready);
endinterface

>>> src/rfg_out_if.sv
// ----------------------------------------------------------------------------
// rfg_out_if: result channel of the fraction reduction block
// Valid/ready channel carrying one reduced fraction per item.
// ----------------------------------------------------------------------------
interface rfg_out_if #(
	parameter int WIDTH = 32
) ();
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] numer_out;
	logic [WIDTH-1:0] denom_out;
	logic [WIDTH-1:0] gcd_out;
	logic             status;

	modport source (output valid, output numer_out, output denom_out, output gcd_out,
		output status, input ready);
	modport sink   (input valid, input numer_out, input denom_out, input gcd_out,
		input status, output ready);
endinterface

>>> src/rfg_dp.sv
// ----------------------------------------------------------------------------
// rfg_dp: datapath of the fraction reduction block
// Binary gcd unit, two restoring dividers sharing the gcd, output register.
// ----------------------------------------------------------------------------
module rfg_dp #(
	parameter int WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rfg_pkg::cmd_t       cmd,
	output rfg_pkg::status_t    stat,
	input  logic [WIDTH-1:0]    numer_in,
	input  logic [WIDTH-1:0]    denom_in,
	output logic [WIDTH-1:0]    numer_out,
	output logic [WIDTH-1:0]    denom_out,
	output logic [WIDTH-1:0]    gcd_out,
	output logic                status
);
	localparam int KW = $clog2(WIDTH);

	logic [WIDTH-1:0] a_q, b_q;      // gcd search operands
	logic [KW-1:0]    k_q;           // common factors of two
	logic [WIDTH-1:0] n_q, d_q;      // dividends, become quotients
	logic [WIDTH-1:0] g_q;           // greatest common divisor
	logic [WIDTH-1:0] rn_q, rd_q;    // division remainders
	logic [WIDTH-1:0] numer_q, denom_q, gcd_q;
	logic             status_q;

	logic [WIDTH-1:0] a_nxt, b_nxt;
	logic [KW-1:0]    k_nxt;
	logic [WIDTH-1:0] diff_ab, diff_ba;
	logic             a_ge_b;
	logic [WIDTH:0]   shn, shd;
	logic [WIDTH:0]   subn, subd;
	logic             qn_bit, qd_bit;

	assign stat.denom_zero = (d_q == '0);
	assign stat.a_zero     = (a_q == '0);

	// one binary gcd step
	always_comb begin
		diff_ab = a_q - b_q;
		diff_ba = b_q - a_q;
		a_ge_b  = (a_q >= b_q);
		a_nxt   = a_q;
		b_nxt   = b_q;
		k_nxt   = k_q;
		case ({a_q[0], b_q[0]})
			2'b00: begin
				a_nxt = a_q >> 1;
				b_nxt = b_q >> 1;
				k_nxt = k_q + KW'(1);
			end
			2'b01: a_nxt = a_q >> 1;
			2'b10: b_nxt = b_q >> 1;
			default: begin
				if (a_ge_b) begin
					a_nxt = diff_ab >> 1;
				end else begin
					b_nxt = diff_ba >> 1;
				end
			end
		endcase
	end

	// one restoring division step on each dividend
	always_comb begin
		shn    = {rn_q, n_q[WIDTH-1]};
		shd    = {rd_q, d_q[WIDTH-1]};
		subn   = shn - {1'b0, g_q};
		subd   = shd - {1'b0, g_q};
		qn_bit = (shn >= {1'b0, g_q});
		qd_bit = (shd >= {1'b0, g_q});
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= numer_in;
			b_q <= denom_in;
			k_q <= '0;
			n_q <= numer_in;
			d_q <= denom_in;
		end else if (cmd.gcd_step) begin
			a_q <= a_nxt;
			b_q <= b_nxt;
			k_q <= k_nxt;
		end else if (cmd.scale) begin
			g_q  <= b_q << k_q;
			rn_q <= '0;
			rd_q <= '0;
		end else if (cmd.div_step) begin
			rn_q <= qn_bit ? subn[WIDTH-1:0] : shn[WIDTH-1:0];
			rd_q <= qd_bit ? subd[WIDTH-1:0] : shd[WIDTH-1:0];
			n_q  <= {n_q[WIDTH-2:0], qn_bit};
			d_q  <= {d_q[WIDTH-2:0], qd_bit};
		end
		if (cmd.out_load) begin
			if (d_q == '0) begin
				numer_q  <= '0;
				denom_q  <= '0;
				gcd_q    <= '0;
				status_q <= 1'b1;
			end else begin
				numer_q  <= n_q;
				denom_q  <= d_q;
				gcd_q    <= g_q;
				status_q <= 1'b0;
			end
		end
	end

	assign numer_out = numer_q;
	assign denom_out = denom_q;
	assign gcd_out   = gcd_q;
	assign status    = status_q;

`ifndef ASSERT_OFF
	// b never reaches zero while the search runs
	a_gcd_b_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.gcd_step |-> b_q != '0)
		else $error("gcd step with zero b operand");
	// gcd is nonzero once scaled
	a_scale_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scale |=> g_q != '0)
		else $error("zero gcd after scale");
	// search step never runs once a has reached zero
	a_step_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.gcd_step |-> a_q != '0)
		else $error("gcd step after search finished");
`endif

endmodule

>>> src/rfg_ctrl.sv
// ----------------------------------------------------------------------------
// rfg_ctrl: controller of the fraction reduction block
// Sequences capture, gcd search, division and result hand-off.
// ----------------------------------------------------------------------------
module rfg_ctrl #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output rfg_pkg::cmd_t    cmd,
	input  rfg_pkg::status_t stat
);
	localparam int CW = $clog2(WIDTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GCD,
		ST_DIV,
		ST_FINISH
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic          out_valid_q;
	logic          out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.gcd_step = (state_q == ST_GCD) && !stat.denom_zero && !stat.a_zero;
		cmd.scale    = (state_q == ST_GCD) && !stat.denom_zero && stat.a_zero;
		cmd.div_step = (state_q == ST_DIV);
		cmd.out_load = (state_q == ST_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_GCD;
					end
				end
				ST_GCD: begin
					if (stat.denom_zero) begin
						state_q <= ST_FINISH;
					end else if (stat.a_zero) begin
						cnt_q   <= CW'(WIDTH - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_FINISH;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	// division runs exactly WIDTH steps, then hands off
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == '0) |=> state_q == ST_FINISH)
		else $error("division did not finish on last step");
	// a result hand-off leaves a valid item and an idle controller
	a_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (out_valid_q && state_q == ST_IDLE))
		else $error("result hand-off incomplete");
	// never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("output register overwritten");
`endif

endmodule

>>> src/reduce_fraction_gcd.sv
// ----------------------------------------------------------------------------
// reduce_fraction_gcd: reduce an unsigned fraction to lowest terms
// Returns numerator/gcd, denominator/gcd and the gcd; flags a zero denominator.
// ----------------------------------------------------------------------------
// One item at a time: an accepted fraction is captured, then runs through
// binary gcd steps (at most about 2*WIDTH steps, often far fewer), one step
// to restore the common factors of two, then WIDTH steps of restoring
// division that form both quotients side by side, and, once the output
// register is free, a move of the result into it. The gcd search loop and
// the one-bit-per-cycle divider take up most of each item's time. The output
// register holds a finished result until it is taken, while the next
// fraction is already being worked on. A zero denominator skips the search
// and gives status 1 with zero results; a zero numerator gives gcd equal to
// the denominator and the result 0/1.
module reduce_fraction_gcd #(
	parameter int WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	rfg_in_if.sink    req,
	rfg_out_if.source rsp
);
	rfg_pkg::cmd_t    cmd;
	rfg_pkg::status_t stat;

	// sequence the item through capture, search, divide and hand-off
	rfg_ctrl #(
		.WIDTH(WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	// gcd unit, dividers and output register
	rfg_dp #(
		.WIDTH(WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.numer_in (req.numer_in),
		.denom_in (req.denom_in),
		.numer_out(rsp.numer_out),
		.denom_out(rsp.denom_out),
		.gcd_out  (rsp.gcd_out),
		.status   (rsp.status)
	);

endmodule

>>> tb/sv/tb_reduce_fraction_gcd.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_reduce_fraction_gcd: self-checking bench for the fraction reduction block
// Drives fractions through the valid/ready request channel in random bursts,
// works out each reduced fraction with Euclid's algorithm and compares every
// returned item field by field, in order, while the result side stalls at
// random and, twice, holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_reduce_fraction_gcd;

	localparam int WIDTH = 32;

	// Run length in items, and hand-shake and run-length limits in clock cycles
	localparam int unsigned RANDOM_ITEMS  = 528;
	localparam int unsigned HOLD_CYCLES   = 800;
	localparam int unsigned SETTLE_CYCLES = 6 * WIDTH + 20;
	localparam int unsigned STALL_LIMIT   = 5000;

	typedef logic [WIDTH-1:0] frac_word_t;

	localparam frac_word_t MAX_VAL = '1;

	typedef struct packed {
		frac_word_t numer;
		frac_word_t denom;
		frac_word_t gcd;
		logic       status;
	} frac_result_t;

	typedef struct packed {
		frac_word_t numer;
		frac_word_t denom;
	} frac_pair_t;

	// One outstanding fraction: what went in and what must come back
	typedef struct {
		frac_word_t   numer_in;
		frac_word_t   denom_in;
		frac_result_t want;
	} frac_owed_t;

	// Stall patterns of the result side
	typedef enum int unsigned {
		SINK_OPEN,   // always ready
		SINK_COIN,   // ready on a coin toss
		SINK_SPARSE, // ready one cycle in four on average
		SINK_COMB    // two ready cycles out of every seven
	} sink_mode_t;

	// ------------------------------------------------------------------------
	// Scoreboard: keep the expected reduced fractions in arrival order and
	// check each returned item against the oldest one.
	// ------------------------------------------------------------------------
	class fraction_scoreboard;
		frac_owed_t  owed_q[$];
		int unsigned n_fractions;
		int unsigned n_checked;
		int unsigned n_mismatch;
		int unsigned n_zero_denom;
		int unsigned n_zero_numer;
		int unsigned n_equal;

		// Euclid's remainder loop; a zero denominator gives the error status
		// with every value field cleared.
		function frac_result_t reduce_fraction(frac_word_t numer, frac_word_t denom);
			frac_result_t res;
			frac_word_t   a;
			frac_word_t   b;
			frac_word_t   r;
			res = '0;
			if (denom == '0) begin
				res.status = 1'b1;
				return res;
			end
			a = numer;
			b = denom;
			while (b != '0) begin
				r = a % b;
				a = b;
				b = r;
			end
			res.gcd   = a;
			res.numer = numer / a;
			res.denom = denom / a;
			return res;
		endfunction

		function void note_fraction(frac_word_t numer, frac_word_t denom);
			frac_owed_t entry;
			entry.numer_in = numer;
			entry.denom_in = denom;
			entry.want     = reduce_fraction(numer, denom);
			owed_q.push_back(entry);
			n_fractions++;
			if (denom == '0)
				n_zero_denom++;
			else if (numer == '0)
				n_zero_numer++;
			else if (numer == denom)
				n_equal++;
		endfunction

		function void compare_field(string field, frac_owed_t entry, frac_word_t want,
				frac_word_t got);
			if (got !== want) begin
				$display("%0t: %s wrong for %0d/%0d: expected %0d, actual %0d",
					$time, field, entry.numer_in, entry.denom_in, want, got);
				n_mismatch++;
			end
		endfunction

		function void check_result(frac_result_t got);
			frac_owed_t entry;
			if (owed_q.size() == 0) begin
				$display("%0t: result %0d/%0d gcd %0d status %0b: expected none, actual one",
					$time, got.numer, got.denom, got.gcd, got.status);
				n_mismatch++;
				return;
			end
			entry = owed_q.pop_front();
			n_checked++;
			compare_field("numer_out", entry, entry.want.numer, got.numer);
			compare_field("denom_out", entry, entry.want.denom, got.denom);
			compare_field("gcd_out", entry, entry.want.gcd, got.gcd);
			compare_field("status", entry, frac_word_t'(entry.want.status),
				frac_word_t'(got.status));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	rfg_in_if  #(.WIDTH(WIDTH)) req_if ();
	rfg_out_if #(.WIDTH(WIDTH)) rsp_if ();

	reduce_fraction_gcd #(
		.WIDTH(WIDTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	fraction_scoreboard sb;

	// Raised by the stimulus to ask the result side for one long hold-off
	bit          hold_due;
	int unsigned n_holds;

	wire req_fire = req_if.valid && req_if.ready;
	wire rsp_fire = rsp_if.valid && rsp_if.ready;

	// Fixed corner fractions: zero denominators, zero numerators, equal
	// values, the extremes of both fields, coprime pairs, pure powers of two
	// and a consecutive Fibonacci pair for the longest Euclid chain.
	frac_pair_t corner_set [22] = '{
		'{32'd0, 32'd0},
		'{32'd5, 32'd0},
		'{32'hFFFF_FFFF, 32'd0},
		'{32'd0, 32'd7},
		'{32'd0, 32'hFFFF_FFFF},
		'{32'd0, 32'd1},
		'{32'd1, 32'd1},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF},
		'{32'd6, 32'd6},
		'{32'd12, 32'd18},
		'{32'd18, 32'd12},
		'{32'd1, 32'hFFFF_FFFF},
		'{32'hFFFF_FFFF, 32'd1},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFE},
		'{32'h8000_0000, 32'h8000_0000},
		'{32'h8000_0000, 32'h0001_0000},
		'{32'hC000_0000, 32'h8000_0000},
		'{32'd2971215073, 32'd1836311903},
		'{32'd4294967291, 32'd4294967279},
		'{32'hAAAA_AAAA, 32'h5555_5555},
		'{32'd1000000, 32'd48},
		'{32'hFFFF_0000, 32'h0000_FFFF}
	};

	// 10 ns clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one fraction from the falling edge and hold it until a rising
	// edge finds ready high. Valid stays up on return so that a following
	// call continues the burst without a gap.
	task automatic drive_fraction(input frac_word_t numer, input frac_word_t denom);
		@(negedge clk);
		req_if.valid    <= 1'b1;
		req_if.numer_in <= numer;
		req_if.denom_in <= denom;
		do
			@(posedge clk);
		while (req_if.ready !== 1'b1);
	endtask

	// Drop valid for a number of cycles; scramble the idle payload so that
	// the block is seen to ignore it.
	task automatic idle_input(input int unsigned cycles);
		repeat (cycles) begin
			@(negedge clk);
			req_if.valid    <= 1'b0;
			req_if.numer_in <= $urandom;
			req_if.denom_in <= $urandom;
		end
	endtask

	// Tap both channels at the rising edge: note every accepted fraction and
	// check every accepted result.
	always @(posedge clk) begin : channel_tap
		frac_result_t got;
		if (arst_n) begin
			if (req_fire)
				sb.note_fraction(req_if.numer_in, req_if.denom_in);
			if (rsp_fire) begin
				got.numer  = rsp_if.numer_out;
				got.denom  = rsp_if.denom_out;
				got.gcd    = rsp_if.gcd_out;
				got.status = rsp_if.status;
				sb.check_result(got);
			end
		end
	end

	// Result side: stall in stretches of random pattern and length, and on
	// request hold ready low for a long, counted stretch so that the output
	// register and the working fraction both fill and the input backs up.
	initial begin : result_sink
		sink_mode_t  mode;
		int unsigned span;
		int unsigned k;
		rsp_if.ready = 1'b0;
		n_holds      = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_due) begin
				@(negedge clk);
				rsp_if.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_due = 1'b0;
				n_holds++;
			end else begin
				mode = sink_mode_t'($urandom_range(0, 3));
				span = $urandom_range(4, 60);
				for (k = 0; k < span; k++) begin
					@(negedge clk);
					case (mode)
					SINK_OPEN: begin
						rsp_if.ready <= 1'b1;
					end
					SINK_COIN: begin
						rsp_if.ready <= 1'($urandom_range(0, 1));
					end
					SINK_SPARSE: begin
						rsp_if.ready <= ($urandom_range(0, 3) == 0);
					end
					default: begin
						rsp_if.ready <= ((k % 7) >= 5);
					end
					endcase
				end
			end
		end
	end

	// Watchdog: end the run once nothing has moved on either channel for
	// far longer than the slowest correct run could take.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (req_fire || rsp_fire)
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: watchdog: no item moved for %0d cycles", $time, STALL_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : stimulus
		frac_word_t  numer;
		frac_word_t  denom;
		frac_word_t  g;
		int unsigned pick;
		int unsigned burst_left;
		sb              = new();
		hold_due        = 1'b0;
		arst_n          = 1'b0;
		req_if.valid    = 1'b0;
		req_if.numer_in = '0;
		req_if.denom_in = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		idle_input(2);

		// Corners first, back to back
		foreach (corner_set[i])
			drive_fraction(corner_set[i].numer, corner_set[i].denom);
		idle_input($urandom_range(1, 20));

		// Random part, sent in bursts; ask for the long hold-off at the start
		// and again half-way through.
		burst_left = $urandom_range(1, 12);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 0 || i == RANDOM_ITEMS / 2)
				hold_due = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				// fully random: every bit of both fields toggles
				numer = $urandom;
				denom = $urandom;
			end else if (pick < 55) begin
				// build a shared factor so that the gcd is usually above one
				g     = $urandom_range(1, 1 << $urandom_range(1, 20));
				numer = g * $urandom_range(0, MAX_VAL / g);
				denom = g * $urandom_range(1, MAX_VAL / g);
			end else if (pick < 65) begin
				// heavy factors of two on both sides
				numer = $urandom << $urandom_range(0, 31);
				denom = ($urandom | 32'd1) << $urandom_range(0, 31);
			end else if (pick < 72) begin
				numer = $urandom;
				denom = '0;
			end else if (pick < 79) begin
				numer = '0;
				denom = $urandom;
			end else if (pick < 85) begin
				numer = $urandom;
				denom = numer;
			end else if (pick < 93) begin
				numer = $urandom_range(0, 255);
				denom = $urandom_range(0, 255);
			end else begin
				// mix of the extremes with random values
				case ($urandom_range(0, 3))
				0: numer = '0;
				1: numer = 32'd1;
				2: numer = MAX_VAL;
				default: numer = $urandom;
				endcase
				case ($urandom_range(0, 3))
				0: denom = '0;
				1: denom = 32'd1;
				2: denom = MAX_VAL;
				default: denom = $urandom;
				endcase
			end
			drive_fraction(numer, denom);
			if (burst_left == 0) begin
				idle_input($urandom_range(1, 15));
				burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
					: $urandom_range(0, 12);
			end else begin
				burst_left--;
			end
		end
		idle_input(1);

		// Drain: wait for every owed result, then let the block settle so
		// that any stray extra item shows up.
		while (sb.owed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d fractions: %0d zero denominators, %0d zero numerators, %0d equal",
			sb.n_fractions, sb.n_zero_denom, sb.n_zero_numer, sb.n_equal);
		$display("checked %0d results across %0d long result-side hold-offs, %0d mismatches",
			sb.n_checked, n_holds, sb.n_mismatch);
		if (sb.n_mismatch == 0 && sb.owed_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> files.f
src/rfg_pkg.sv
src/rfg_in_if.sv
src/rfg_out_if.sv
src/rfg_dp.sv
src/rfg_ctrl.sv
src/reduce_fraction_gcd.sv
tb/sv/tb_reduce_fraction_gcd.sv
